/* src/psc_pkg.sv */
package psc_pkg;

  // default sizes
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int COORD_BITS_DEF  = 24;

  // fixed field widths
  localparam int SLOT_W    = 4;
  localparam int COUNT_W   = 5;
  localparam int RADIUS_W  = 24;
  localparam int RSUM_W    = RADIUS_W + 1;
  localparam int CAT_W     = 4;
  localparam int KIND_W    = CAT_W + 2;
  localparam int LIMIT_W   = 52;
  localparam int HITCNT_W  = 4;
  localparam int PRIO_W    = 7;

  // at most this many hits per row, the end marker takes the last place
  localparam logic [HITCNT_W-1:0] MAX_HITS = 4'd15;

  // command codes carried in tuser
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  // category codes
  localparam logic [CAT_W-1:0] CAT_COLLECT = 4'd0;
  localparam logic [CAT_W-1:0] CAT_SOLID   = 4'd1;
  localparam logic [CAT_W-1:0] CAT_ATTACK  = 4'd2;
  localparam logic [CAT_W-1:0] CAT_INVINC  = 4'd3;
  localparam logic [CAT_W-1:0] CAT_ENEMY   = 4'd4;
  localparam logic [CAT_W-1:0] CAT_PLAYER  = 4'd5;
  localparam logic [CAT_W-1:0] CAT_PSHOT   = 4'd6;
  localparam logic [CAT_W-1:0] CAT_ESHOT   = 4'd7;
  localparam logic [CAT_W-1:0] CAT_GOAL    = 4'd8;

  // priorities
  localparam logic [PRIO_W-1:0] PRIO_COLLECT = 7'd120;
  localparam logic [PRIO_W-1:0] PRIO_OBJECT  = 7'd100;
  localparam logic [PRIO_W-1:0] PRIO_PLAYER  = 7'd80;
  localparam logic [PRIO_W-1:0] PRIO_SHOT    = 7'd50;
  localparam logic [PRIO_W-1:0] PRIO_GOAL    = 7'd10;
  localparam logic [PRIO_W-1:0] PRIO_NONE    = 7'd0;

  // controller to datapath commands
  typedef struct packed {
    logic wr_en;
    logic row_rd;
    logic row_latch;
    logic walk_rd;
    logic end_push;
    logic clear;
  } psc_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic adv;
    logic row_present;
    logic pipe_empty;
  } psc_sts_t;

  function automatic logic [PRIO_W-1:0] priority_of(input logic [CAT_W-1:0] cat);
    logic [PRIO_W-1:0] p;
    case (cat)
      CAT_COLLECT: p = PRIO_COLLECT;
      CAT_SOLID, CAT_ATTACK, CAT_INVINC, CAT_ENEMY: p = PRIO_OBJECT;
      CAT_PLAYER: p = PRIO_PLAYER;
      CAT_PSHOT, CAT_ESHOT: p = PRIO_SHOT;
      CAT_GOAL: p = PRIO_GOAL;
      default: p = PRIO_NONE;
    endcase
    return p;
  endfunction

  function automatic logic pair_allowed(input logic [CAT_W-1:0] a,
                                        input logic [CAT_W-1:0] b);
    logic [CAT_W-1:0] lo;
    logic [CAT_W-1:0] hi;
    logic ok;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (lo == hi) begin
      ok = 1'b0;
    end else if (hi == CAT_PLAYER) begin
      ok = (lo <= CAT_ENEMY);
    end else if (lo == CAT_PLAYER) begin
      ok = (hi == CAT_ESHOT) || (hi == CAT_GOAL);
    end else begin
      ok = (hi == CAT_PSHOT) && ((lo == CAT_ATTACK) || (lo == CAT_ENEMY));
    end
    return ok;
  endfunction

endpackage

/* src/psc_ctrl.sv */
module psc_ctrl
  import psc_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int IDX_W = $clog2(MAX_ENTRIES),
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_cmd,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic [COUNT_W-1:0] in_count,
  output logic               in_ready,
  input  psc_sts_t           sts,
  output psc_ctl_t           ctl,
  output logic [IDX_W-1:0]   rd_addr
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_RD,
    ST_ROW_LATCH,
    ST_WALK,
    ST_DRAIN,
    ST_END
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] j;
  logic [CNT_W-1:0] cnt;

  logic             accept;
  logic [CNT_W-1:0] cnt_clamped;
  logic             row_in_range;
  logic             row_none_after;
  logic             j_is_last;

  // input decode
  assign accept       = in_valid && in_ready;
  assign cnt_clamped  = (int'(in_count) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                       : CNT_W'(in_count);
  assign row_in_range = int'(in_slot) < int'(cnt_clamped);

  // walk bounds
  assign row_none_after = (CNT_W'(row) + CNT_W'(1)) >= cnt;
  assign j_is_last      = (CNT_W'(j) + CNT_W'(1)) == cnt;

  // commands
  always_comb begin
    ctl           = '0;
    in_ready      = (state == ST_IDLE);
    ctl.wr_en     = accept && (in_cmd == CMD_LOAD) && (int'(in_slot) < MAX_ENTRIES);
    ctl.row_rd    = (state == ST_ROW_RD);
    ctl.clear     = (state == ST_ROW_RD);
    ctl.row_latch = (state == ST_ROW_LATCH);
    ctl.walk_rd   = (state == ST_WALK) && sts.adv;
    ctl.end_push  = (state == ST_END);
    rd_addr       = (state == ST_WALK) ? j : row;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && (in_cmd == CMD_CHECK)) begin
            row <= IDX_W'(in_slot);
            cnt <= cnt_clamped;
            state <= row_in_range ? ST_ROW_RD : ST_END;
          end
        end
        ST_ROW_RD: begin
          state <= ST_ROW_LATCH;
        end
        ST_ROW_LATCH: begin
          j <= row + IDX_W'(1);
          if (!sts.row_present || row_none_after) begin
            state <= ST_END;
          end else begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (sts.adv) begin
            if (j_is_last) begin
              state <= ST_DRAIN;
            end else begin
              j <= j + IDX_W'(1);
            end
          end
        end
        ST_DRAIN: begin
          if (sts.pipe_empty) begin
            state <= ST_END;
          end
        end
        ST_END: begin
          if (sts.adv) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (CNT_W'(j) < cnt))
    else $error("walk index past slot count");

  a_walk_on_adv: assert property (@(posedge clk) disable iff (rst)
    ctl.walk_rd |-> sts.adv)
    else $error("slot read issued while pipeline stalled");

  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_END) && sts.adv |=> (state == ST_IDLE))
    else $error("end marker sent but row not closed");

endmodule

/* src/psc_datapath.sv */
module psc_datapath
  import psc_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_ENTRIES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  psc_ctl_t              ctl,
  output psc_sts_t              sts,
  input  logic [IDX_W-1:0]      rd_addr,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [COORD_BITS-1:0] in_pos_x,
  input  logic [COORD_BITS-1:0] in_pos_y,
  input  logic [COORD_BITS-1:0] in_pos_z,
  input  logic [RADIUS_W-1:0]   in_radius,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic                  cfg_we,
  input  logic [LIMIT_W-1:0]    cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SLOT_W-1:0]     out_first,
  output logic [SLOT_W-1:0]     out_second,
  output logic                  out_hit,
  output logic                  out_last
);

  localparam int CB     = COORD_BITS;
  localparam int X_LO   = 0;
  localparam int Y_LO   = CB;
  localparam int Z_LO   = 2 * CB;
  localparam int R_LO   = 3 * CB;
  localparam int K_LO   = R_LO + RADIUS_W;
  localparam int WORD_W = K_LO + KIND_W;
  localparam int SQ_W   = 2 * CB;
  localparam int SUM_W  = SQ_W + 2;
  localparam int CMP_W  = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
  localparam int RS2_W  = 2 * RSUM_W;

  // collider store, one word per slot
  logic [WORD_W-1:0] mem [MAX_ENTRIES];
  logic [WORD_W-1:0] mem_q;

  // broad-phase limit
  logic [LIMIT_W-1:0] limit;

  // row collider
  logic [IDX_W-1:0]    row_idx;
  logic [CB-1:0]       row_x;
  logic [CB-1:0]       row_y;
  logic [CB-1:0]       row_z;
  logic [RADIUS_W-1:0] row_r;
  logic [CAT_W-1:0]    row_cat;
  logic                row_col;

  // pipeline stages
  logic             m_valid;
  logic [IDX_W-1:0] m_j;

  logic              s1_valid;
  logic              s1_ok;
  logic [IDX_W-1:0]  s1_first;
  logic [IDX_W-1:0]  s1_second;
  logic [CB-1:0]     s1_ax;
  logic [CB-1:0]     s1_ay;
  logic [CB-1:0]     s1_az;
  logic [RSUM_W-1:0] s1_rs;

  logic              s2_valid;
  logic              s2_ok;
  logic [IDX_W-1:0]  s2_first;
  logic [IDX_W-1:0]  s2_second;
  logic [SQ_W-1:0]   s2_sx;
  logic [SQ_W-1:0]   s2_sy;
  logic [SQ_W-1:0]   s2_sz;
  logic [RS2_W-1:0]  s2_rs2;

  logic [HITCNT_W-1:0] hit_cnt;

  logic                adv;
  logic [CAT_W-1:0]    m_cat;
  logic                m_col;
  logic                m_present;
  logic                m_swap;
  logic                pair_ok;
  logic [SUM_W-1:0]    d2;
  logic                s2_hit;
  logic                push_hit;

  function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a,
                                             input logic [CB-1:0] b);
    logic signed [CB:0] d;
    d = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
    return d[CB] ? CB'(-d) : CB'(d);
  endfunction

  // handshake status
  assign adv             = !out_valid || out_ready;
  assign sts.adv         = adv;
  assign sts.row_present = mem_q[K_LO + KIND_W - 1];
  assign sts.pipe_empty  = !m_valid && !s1_valid && !s2_valid;

  // store write and registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[IDX_W'(in_slot)] <= {in_kind, in_radius, in_pos_z, in_pos_y, in_pos_x};
    end
    if (ctl.row_rd || ctl.walk_rd) begin
      mem_q <= mem[rd_addr];
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '1;
    end else if (cfg_we) begin
      limit <= cfg_wdata;
    end
  end

  // row capture
  always_ff @(posedge clk) begin
    if (ctl.row_rd) begin
      row_idx <= rd_addr;
    end
    if (ctl.row_latch) begin
      row_x   <= mem_q[X_LO +: CB];
      row_y   <= mem_q[Y_LO +: CB];
      row_z   <= mem_q[Z_LO +: CB];
      row_r   <= mem_q[R_LO +: RADIUS_W];
      row_cat <= mem_q[K_LO +: CAT_W];
      row_col <= mem_q[K_LO + CAT_W];
    end
  end

  // pair filter of the slot just read
  assign m_cat     = mem_q[K_LO +: CAT_W];
  assign m_col     = mem_q[K_LO + CAT_W];
  assign m_present = mem_q[K_LO + CAT_W + 1];
  assign pair_ok   = m_present && pair_allowed(row_cat, m_cat) && row_col && m_col;
  assign m_swap    = priority_of(m_cat) > priority_of(row_cat);

  // squared distance and hit test
  assign d2     = SUM_W'(s2_sx) + SUM_W'(s2_sy) + SUM_W'(s2_sz);
  assign s2_hit = s2_ok && (CMP_W'(d2) <= CMP_W'(limit)) && (CMP_W'(d2) <= CMP_W'(s2_rs2));
  assign push_hit = s2_valid && s2_hit && (hit_cnt < MAX_HITS);

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid  <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      m_valid  <= ctl.walk_rd;
      s1_valid <= m_valid;
      s2_valid <= s1_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      m_j       <= rd_addr;
      s1_ok     <= pair_ok;
      s1_first  <= m_swap ? m_j : row_idx;
      s1_second <= m_swap ? row_idx : m_j;
      s1_ax     <= abs_diff(mem_q[X_LO +: CB], row_x);
      s1_ay     <= abs_diff(mem_q[Y_LO +: CB], row_y);
      s1_az     <= abs_diff(mem_q[Z_LO +: CB], row_z);
      s1_rs     <= RSUM_W'(mem_q[R_LO +: RADIUS_W]) + RSUM_W'(row_r);
      s2_ok     <= s1_ok;
      s2_first  <= s1_first;
      s2_second <= s1_second;
      s2_sx     <= SQ_W'(s1_ax) * SQ_W'(s1_ax);
      s2_sy     <= SQ_W'(s1_ay) * SQ_W'(s1_ay);
      s2_sz     <= SQ_W'(s1_az) * SQ_W'(s1_az);
      s2_rs2    <= RS2_W'(s1_rs) * RS2_W'(s1_rs);
    end
  end

  // hit counter and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hit_cnt   <= '0;
    end else begin
      if (ctl.clear) begin
        hit_cnt <= '0;
      end
      if (adv) begin
        if (push_hit) begin
          out_valid  <= 1'b1;
          out_first  <= SLOT_W'(s2_first);
          out_second <= SLOT_W'(s2_second);
          out_hit    <= 1'b1;
          out_last   <= 1'b0;
          hit_cnt    <= hit_cnt + HITCNT_W'(1);
        end else if (ctl.end_push) begin
          out_valid  <= 1'b1;
          out_first  <= '0;
          out_second <= '0;
          out_hit    <= 1'b0;
          out_last   <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  // checks
  a_end_after_drain: assert property (@(posedge clk) disable iff (rst)
    ctl.end_push |-> (!m_valid && !s1_valid && !s2_valid))
    else $error("end marker while pair tests in flight");

  a_hit_cap: assert property (@(posedge clk) disable iff (rst)
    hit_cnt <= MAX_HITS)
    else $error("hit counter past row limit");

  a_hit_xor_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_hit != out_last))
    else $error("result is neither a hit nor an end marker");

endmodule

/* src/pairwise_sphere_collision_unit.sv */
// load: writes its slot when accepted, no result
// check of row i: row fetch (ROW_RD, ROW_LATCH), one pair test per cycle for slots i+1 to
// count-1 while the output is not stalled, pipeline drain, end marker; an empty row or no
// slot after it skips walk and drain, a row out of range the fetch too; one slot read port
// sets the pace; results pass read, s1, s2, out regs; output stalls hold the whole walk
// synchronous rst clears control, pipeline and output, broad limit to all ones, not slots
module pairwise_sphere_collision_unit
  import psc_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF,
  localparam int IN_BITS = SLOT_W + COUNT_W + 3 * COORD_BITS + RADIUS_W + CAT_W + 2,
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // slot, count, pos_x, pos_y, pos_z, radius, category, collidable, present
  input  logic [IN_W-1:0]    s_axis_tdata,
  // cmd
  input  logic               s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // first_slot, second_slot
  output logic [7:0]         m_axis_tdata,
  // hit
  output logic               m_axis_tuser,
  output logic               m_axis_tlast
);

  localparam int IDX_W   = $clog2(MAX_ENTRIES);
  localparam int CB      = COORD_BITS;
  localparam int SLOT_LO = 0;
  localparam int CNT_LO  = SLOT_LO + SLOT_W;
  localparam int X_LO    = CNT_LO + COUNT_W;
  localparam int Y_LO    = X_LO + CB;
  localparam int Z_LO    = Y_LO + CB;
  localparam int R_LO    = Z_LO + CB;
  localparam int K_LO    = R_LO + RADIUS_W;

  psc_ctl_t          ctl;
  psc_sts_t          sts;
  logic [IDX_W-1:0]  rd_addr;
  logic [SLOT_W-1:0] out_first;
  logic [SLOT_W-1:0] out_second;

  // controller
  psc_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser),
    .in_slot  (s_axis_tdata[SLOT_LO +: SLOT_W]),
    .in_count (s_axis_tdata[CNT_LO +: COUNT_W]),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .ctl      (ctl),
    .rd_addr  (rd_addr)
  );

  // datapath
  psc_datapath #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .rd_addr    (rd_addr),
    .in_slot    (s_axis_tdata[SLOT_LO +: SLOT_W]),
    .in_pos_x   (s_axis_tdata[X_LO +: CB]),
    .in_pos_y   (s_axis_tdata[Y_LO +: CB]),
    .in_pos_z   (s_axis_tdata[Z_LO +: CB]),
    .in_radius  (s_axis_tdata[R_LO +: RADIUS_W]),
    .in_kind    (s_axis_tdata[K_LO +: KIND_W]),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_first  (out_first),
    .out_second (out_second),
    .out_hit    (m_axis_tuser),
    .out_last   (m_axis_tlast)
  );

  // result packing
  assign m_axis_tdata = {out_second, out_first};

endmodule

/* dv/collision_pair_checker.sv */
`timescale 1ns / 100ps

module collision_pair_checker
  import psc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [111:0]       s_axis_tdata,
  input  logic               s_axis_tuser,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [7:0]         m_axis_tdata,
  input  logic               m_axis_tuser,
  input  logic               m_axis_tlast,
  output int                 errors,
  output int                 pending
);

  localparam int SLOTS = MAX_ENTRIES_DEF;

  // input beat layout, lowest field last
  typedef struct packed {
    logic              pad;
    logic              present;
    logic              collidable;
    logic [CAT_W-1:0]  category;
    logic [23:0]       radius;
    logic [23:0]       pos_z;
    logic [23:0]       pos_y;
    logic [23:0]       pos_x;
    logic [COUNT_W-1:0] count;
    logic [SLOT_W-1:0] slot;
  } collider_beat_t;

  typedef struct packed {
    logic [SLOT_W-1:0] first;
    logic [SLOT_W-1:0] second;
    logic              hit;
    logic              last;
  } pair_beat_t;

  // shadow copy of the collider slots and the broad limit
  logic signed [23:0] pos_q  [SLOTS][3];
  logic [23:0]        rad_q  [SLOTS];
  logic [CAT_W-1:0]   cat_q  [SLOTS];
  logic               coll_q [SLOTS];
  logic               pres_q [SLOTS];
  logic [LIMIT_W-1:0] limit_q;

  pair_beat_t     pairs_due[$];
  collider_beat_t item_in;
  pair_beat_t     want;

  function automatic int unsigned rank_of(input logic [CAT_W-1:0] c);
    if (c == CAT_COLLECT) return PRIO_COLLECT;
    if (c <= CAT_ENEMY) return PRIO_OBJECT;
    if (c == CAT_PLAYER) return PRIO_PLAYER;
    if (c == CAT_PSHOT || c == CAT_ESHOT) return PRIO_SHOT;
    if (c == CAT_GOAL) return PRIO_GOAL;
    return PRIO_NONE;
  endfunction

  // player meets most kinds, player shot only attackables and enemies
  function automatic bit may_collide(input logic [CAT_W-1:0] a, input logic [CAT_W-1:0] b);
    logic [CAT_W-1:0] other;
    if (a == b) return 1'b0;
    if (a == CAT_PLAYER || b == CAT_PLAYER) begin
      other = (a == CAT_PLAYER) ? b : a;
      case (other)
        CAT_COLLECT, CAT_SOLID, CAT_ATTACK, CAT_INVINC, CAT_ENEMY,
        CAT_ESHOT, CAT_GOAL: return 1'b1;
        default: return 1'b0;
      endcase
    end
    if (a == CAT_PSHOT || b == CAT_PSHOT) begin
      other = (a == CAT_PSHOT) ? b : a;
      return (other == CAT_ATTACK) || (other == CAT_ENEMY);
    end
    return 1'b0;
  endfunction

  // squared center distance, saturating at 64 bits
  function automatic logic [63:0] span_sq(input int unsigned a, input int unsigned b);
    logic [64:0] acc;
    longint      d;
    logic [63:0] ad;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      d   = longint'(pos_q[a][k]) - longint'(pos_q[b][k]);
      ad  = (d < 0) ? -d : d;
      acc = acc + (ad * ad);
      if (acc[64]) acc = {1'b0, {64{1'b1}}};
    end
    return acc[63:0];
  endfunction

  // expected beats of one row walk
  task automatic predict_row(input int unsigned row, input int unsigned count);
    int unsigned lim;
    int unsigned hits;
    logic [63:0] d2;
    logic [25:0] rsum;
    logic [63:0] rsq;
    pair_beat_t  b;
    lim  = (count > SLOTS) ? SLOTS : count;
    hits = 0;
    if (row < lim && pres_q[row]) begin
      for (int unsigned j = row + 1; j < lim && hits < MAX_HITS; j++) begin
        if (!pres_q[j] || !may_collide(cat_q[row], cat_q[j])) continue;
        d2 = span_sq(row, j);
        if (d2 > limit_q) continue;
        if (!coll_q[row] || !coll_q[j]) continue;
        rsum = 26'(rad_q[row]) + 26'(rad_q[j]);
        rsq  = 64'(rsum) * 64'(rsum);
        if (d2 > rsq) continue;
        b.hit  = 1'b1;
        b.last = 1'b0;
        if (rank_of(cat_q[j]) > rank_of(cat_q[row])) begin
          b.first  = SLOT_W'(j);
          b.second = SLOT_W'(row);
        end else begin
          b.first  = SLOT_W'(row);
          b.second = SLOT_W'(j);
        end
        pairs_due.push_back(b);
        hits++;
      end
    end
    b      = '0;
    b.last = 1'b1;
    pairs_due.push_back(b);
  endtask

  task automatic flag_error(input string what, input pair_beat_t exp_b);
    errors++;
    if (errors <= 10) begin
      $display("%0t %s: expected first %0d second %0d hit %0d last %0d,",
               $time, what, exp_b.first, exp_b.second, exp_b.hit, exp_b.last,
               " got first %0d second %0d hit %0d last %0d",
               m_axis_tdata[3:0], m_axis_tdata[7:4], m_axis_tuser, m_axis_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      limit_q = '1;
      pairs_due.delete();
    end else begin
      if (cfg_we) limit_q = cfg_wdata;

      // result beat against the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        if (pairs_due.size() == 0) begin
          flag_error("unexpected beat", '0);
        end else begin
          want = pairs_due.pop_front();
          if (m_axis_tdata[3:0] !== want.first || m_axis_tdata[7:4] !== want.second ||
              m_axis_tuser !== want.hit || m_axis_tlast !== want.last) begin
            flag_error("mismatch", want);
          end
        end
      end

      // command beat: update slots or predict a row
      if (s_axis_tvalid && s_axis_tready) begin
        item_in = s_axis_tdata;
        if (s_axis_tuser == CMD_LOAD) begin
          pos_q[item_in.slot][0] = item_in.pos_x;
          pos_q[item_in.slot][1] = item_in.pos_y;
          pos_q[item_in.slot][2] = item_in.pos_z;
          rad_q[item_in.slot]    = item_in.radius;
          cat_q[item_in.slot]    = item_in.category;
          coll_q[item_in.slot]   = item_in.collidable;
          pres_q[item_in.slot]   = item_in.present;
        end else begin
          predict_row(32'(item_in.slot), 32'(item_in.count));
        end
      end
    end
    pending = pairs_due.size();
  end

endmodule

/* dv/pairwise_sphere_collision_unit_test.sv */
`timescale 1ns / 100ps

module pairwise_sphere_collision_unit_test;
  import psc_pkg::*;

  localparam int IN_W  = 112;
  localparam int DRAIN = 32;

  localparam logic [CAT_W-1:0] CAT_OTHER  = 4'd9;
  localparam logic [CAT_W-1:0] CAT_UNUSED = 4'd15;

  localparam logic [23:0] C_MAX = 24'h7FFFFF;
  localparam logic [23:0] C_MIN = 24'h800000;
  localparam logic [23:0] R_MAX = 24'hFFFFFF;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata;
  logic               s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [7:0]         m_axis_tdata;
  logic               m_axis_tuser;
  logic               m_axis_tlast;

  int   errors;
  int   pending;
  int   items_sent;
  logic no_gaps;

  pairwise_sphere_collision_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  collision_pair_checker pair_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .errors        (errors),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side backpressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready <= no_gaps || ($urandom_range(99) >= 17);
    end
  end

  function automatic logic [IN_W-1:0] pack_item(
    input logic [SLOT_W-1:0] slot, input logic [COUNT_W-1:0] count,
    input logic [23:0] x, input logic [23:0] y, input logic [23:0] z,
    input logic [23:0] r, input logic [CAT_W-1:0] cat, input logic coll, input logic pres);
    return {1'b0, pres, coll, cat, r, z, y, x, count, slot};
  endfunction

  // one command beat, with random gaps before it
  task automatic send_beat(input logic cmd, input logic [IN_W-1:0] data);
    while (!no_gaps && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_slot(input logic [SLOT_W-1:0] slot, input logic [23:0] x,
                           input logic [23:0] y, input logic [23:0] z, input logic [23:0] r,
                           input logic [CAT_W-1:0] cat, input logic coll, input logic pres);
    send_beat(CMD_LOAD, pack_item(slot, COUNT_W'($urandom), x, y, z, r, cat, coll, pres));
  endtask

  // unused fields carry noise on a check
  task automatic check_row(input logic [SLOT_W-1:0] row, input logic [COUNT_W-1:0] count);
    send_beat(CMD_CHECK, pack_item(row, count, 24'($urandom), 24'($urandom), 24'($urandom),
                                   24'($urandom), CAT_W'($urandom), 1'($urandom),
                                   1'($urandom)));
  endtask

  // wait until the unit is idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [23:0] near(input int c, input int spread);
    return 24'(c + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // a cluster of colliders followed by a few row checks, or one noise beat
  task automatic run_scene();
    int n;
    int spread;
    int rows;
    int cx;
    int cy;
    int cz;
    int pick;
    logic [CAT_W-1:0] cat;
    if ($urandom_range(99) < 85) begin
      n      = $urandom_range(2, 16);
      spread = 1 << $urandom_range(4, 13);
      cx     = int'($urandom_range(0, 1 << 23)) - (1 << 22);
      cy     = int'($urandom_range(0, 1 << 23)) - (1 << 22);
      cz     = int'($urandom_range(0, 1 << 23)) - (1 << 22);
      for (int k = 0; k < n; k++) begin
        pick = $urandom_range(99);
        if (pick < 30) cat = CAT_PLAYER;
        else if (pick < 45) cat = CAT_PSHOT;
        else if (pick < 92) cat = CAT_W'($urandom_range(0, 8));
        else cat = CAT_W'($urandom_range(9, 15));
        load_slot(SLOT_W'(k), near(cx, spread), near(cy, spread), near(cz, spread),
                  24'($urandom_range(0, spread)), cat, $urandom_range(99) < 90,
                  $urandom_range(99) < 92);
      end
      rows = $urandom_range(1, 4);
      for (int k = 0; k < rows; k++) begin
        check_row(SLOT_W'($urandom_range(0, n - 1)),
                  COUNT_W'(($urandom_range(99) < 80) ? n : int'($urandom_range(0, 31))));
      end
      items_sent += n + rows;
    end else begin
      if ($urandom_range(1)) begin
        load_slot(SLOT_W'($urandom_range(15)), 24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom), CAT_W'($urandom_range(15)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end else begin
        check_row(SLOT_W'($urandom_range(15)), COUNT_W'($urandom_range(31)));
      end
      items_sent += 1;
    end
  endtask

  initial begin
    int goal;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_LOAD;
    no_gaps       = 1'b0;
    items_sent    = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // every slot written before any row reads it, limit at its reset value
    load_slot(0,  24'h0, 24'h0, 24'h0, 24'h100, CAT_PLAYER, 1'b1, 1'b1);
    load_slot(1,  24'h80, 24'h0, 24'h0, 24'h100, CAT_ENEMY, 1'b1, 1'b1);
    load_slot(2,  C_MAX, C_MAX, C_MAX, R_MAX, CAT_COLLECT, 1'b1, 1'b1);
    load_slot(3,  C_MIN, C_MIN, C_MIN, R_MAX, CAT_ESHOT, 1'b1, 1'b1);
    load_slot(4,  24'h0, 24'h0, 24'h0, 24'h100, CAT_SOLID, 1'b0, 1'b1);
    load_slot(5,  24'h0, 24'h0, 24'h0, 24'h100, CAT_INVINC, 1'b1, 1'b0);
    load_slot(6,  24'h40, 24'h40, 24'h40, 24'h80, CAT_PSHOT, 1'b1, 1'b1);
    load_slot(7,  24'h40, 24'h40, 24'hC0, 24'h40, CAT_ATTACK, 1'b1, 1'b1);
    // touching exactly at the radius sum
    load_slot(8,  24'h0, 24'h0, 24'h100, 24'h0, CAT_GOAL, 1'b1, 1'b1);
    load_slot(9,  24'h0, 24'h0, 24'h0, 24'h100, CAT_OTHER, 1'b1, 1'b1);
    load_slot(10, 24'h0, 24'h0, 24'h0, 24'h100, CAT_UNUSED, 1'b1, 1'b1);
    // one unit beyond the radius sum
    load_slot(11, 24'h0, 24'h0, 24'h201, 24'h100, CAT_ENEMY, 1'b1, 1'b1);
    load_slot(12, 24'h10, 24'h20, 24'h30, 24'h50, CAT_PLAYER, 1'b1, 1'b1);
    load_slot(13, 24'hFFFFF0, 24'hFFFFF0, 24'hFFFFF0, 24'h0, CAT_ENEMY, 1'b1, 1'b1);
    load_slot(14, C_MAX, C_MIN, 24'h0, 24'h123456, CAT_ATTACK, 1'b1, 1'b1);
    load_slot(15, C_MAX, C_MAX, C_MAX, R_MAX, CAT_PLAYER, 1'b1, 1'b1);
    check_row(0, 16);
    check_row(0, 31);   // count clamps to the slot total
    check_row(2, 16);
    check_row(3, 16);
    check_row(6, 16);
    check_row(5, 16);   // empty row slot
    check_row(15, 16);  // nothing after the last slot
    check_row(8, 8);    // row not below count
    check_row(1, 0);

    // random scenes under several broad limits
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: write_limit('1);
        1: write_limit('0);
        2: write_limit(LIMIT_W'($urandom_range(0, 1 << 26)));
        3: write_limit(LIMIT_W'({$urandom, $urandom}));
        4: write_limit(LIMIT_W'($urandom_range(0, 1 << 20)));
        default: write_limit('1);
      endcase
      no_gaps <= (ph == 2);
      goal = items_sent + 70;
      while (items_sent < goal) run_scene();
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
src/psc_pkg.sv
src/psc_ctrl.sv
src/psc_datapath.sv
src/pairwise_sphere_collision_unit.sv
dv/collision_pair_checker.sv
dv/pairwise_sphere_collision_unit_test.sv
